FILE: rtl/stbs_pkg.sv
// Shared constants, codes and control types of the sorted table search unit.
package stbs_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int DATA_W      = 32;
    localparam int POS_W       = 10;
    localparam int CMD_W       = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

    // Datapath operations driven by the control word
    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_APPEND,
        OP_ZERO,
        OP_SINIT,
        OP_READ,
        OP_CMP
    } dp_op_t;

    // Jump conditions: true goes to target (for dispatch, the decoded command), false goes to alt
    typedef enum logic [2:0] {
        J_ALWAYS,
        J_DISPATCH,
        J_EMPTY,
        J_MISS,
        J_SLOT
    } jump_t;

    // Microprogram step addresses
    typedef enum logic [2:0] {
        S_IDLE,
        S_CLR,
        S_APP,
        S_NOP,
        S_SRCH,
        S_READ,
        S_CMP,
        S_PUSH
    } step_t;

    // One microcode word
    typedef struct packed {
        dp_op_t op;
        jump_t  jmp;
        step_t  target;
        step_t  alt;
        logic   in_ready;
        logic   res_load;
    } ucode_t;

    // Sequencer to datapath
    typedef struct packed {
        dp_op_t op;
        logic   latch;
        logic   push;
    } dp_ctrl_t;

    // Datapath to sequencer
    typedef struct packed {
        logic empty;
        logic match;
        logic slot_free;
    } dp_stat_t;

endpackage

FILE: rtl/stbs_sequencer.sv
// Microcode ROM, step counter and jump logic of the search unit.
module stbs_sequencer
    import stbs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [CMD_W-1:0] command,
    input  dp_stat_t         stat,
    output logic             in_ready,
    output dp_ctrl_t         ctrl
);

    // Control store: one word per step
    function automatic ucode_t ucode(input step_t s);
        ucode_t w;
        w = '{op: OP_NONE, jmp: J_ALWAYS, target: S_IDLE, alt: S_IDLE,
              in_ready: 1'b0, res_load: 1'b0};
        unique case (s)
            S_IDLE: begin
                w.jmp      = J_DISPATCH;
                w.alt      = S_IDLE;
                w.in_ready = 1'b1;
            end
            S_CLR: begin
                w.op     = OP_CLEAR;
                w.target = S_PUSH;
            end
            S_APP: begin
                w.op     = OP_APPEND;
                w.target = S_PUSH;
            end
            S_NOP: begin
                w.op     = OP_ZERO;
                w.target = S_PUSH;
            end
            S_SRCH: begin
                w.op     = OP_SINIT;
                w.target = S_READ;
            end
            S_READ: begin
                w.op     = OP_READ;
                w.jmp    = J_EMPTY;
                w.target = S_PUSH;
                w.alt    = S_CMP;
            end
            S_CMP: begin
                w.op     = OP_CMP;
                w.jmp    = J_MISS;
                w.target = S_READ;
                w.alt    = S_PUSH;
            end
            S_PUSH: begin
                w.jmp      = J_SLOT;
                w.target   = S_IDLE;
                w.alt      = S_PUSH;
                w.res_load = 1'b1;
            end
            default: ;
        endcase
        return w;
    endfunction

    step_t  step_reg;
    step_t  step_next;
    ucode_t uc;
    step_t  dispatch;

    assign uc = ucode(step_reg);

    // Command decode for the dispatch jump
    always_comb
    begin
        unique case (command)
            CMD_CLEAR:  dispatch = S_CLR;
            CMD_APPEND: dispatch = S_APP;
            CMD_SEARCH: dispatch = S_SRCH;
            default:    dispatch = S_NOP;
        endcase
    end

    // Next step
    always_comb
    begin
        unique case (uc.jmp)
            J_ALWAYS:   step_next = uc.target;
            J_DISPATCH: step_next = in_valid ? dispatch : uc.alt;
            J_EMPTY:    step_next = stat.empty ? uc.target : uc.alt;
            J_MISS:     step_next = stat.match ? uc.alt : uc.target;
            J_SLOT:     step_next = stat.slot_free ? uc.target : uc.alt;
            default:    step_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= S_IDLE;
        else
            step_reg <= step_next;
    end

    // Control outputs
    assign in_ready   = uc.in_ready;
    assign ctrl.op    = uc.op;
    assign ctrl.latch = uc.in_ready & in_valid;
    assign ctrl.push  = uc.res_load & stat.slot_free;

endmodule

FILE: rtl/stbs_datapath.sv
// Table memory, search bounds, compare and output register of the search unit.
module stbs_datapath
    import stbs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_ctrl_t                 ctrl,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     out_ready,
    output dp_stat_t                 stat,
    output logic                     out_valid,
    output logic                     found,
    output logic [POS_W-1:0]         position,
    output logic                     table_full
);

    logic [DATA_W-1:0]        mem [TABLE_DEPTH];

    logic signed [DATA_W-1:0] key_reg;
    logic signed [DATA_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]         mid_reg;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         low_reg, low_next;
    logic [CNT_W-1:0]         hi1_reg, hi1_next;
    logic                     wfound_reg, wfound_next;
    logic [IDX_W-1:0]         wpos_reg, wpos_next;
    logic                     wfull_reg, wfull_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     found_reg;
    logic [POS_W-1:0]         position_reg;
    logic                     table_full_reg;

    logic                     is_full;
    logic [CNT_W:0]           mid_sum;
    logic [IDX_W-1:0]         mid_comb;
    logic                     key_lt;
    logic                     key_eq;

    // high is kept as high+1 so both bounds stay unsigned
    assign mid_sum  = {1'b0, low_reg} + {1'b0, hi1_reg} - {{CNT_W{1'b0}}, 1'b1};
    assign mid_comb = mid_sum[IDX_W:1];
    assign is_full  = (count_reg >= CNT_W'(TABLE_DEPTH));
    assign key_lt   = (key_reg < rd_data_reg);
    assign key_eq   = (key_reg == rd_data_reg);

    assign stat.empty     = (low_reg >= hi1_reg);
    assign stat.match     = key_eq;
    assign stat.slot_free = ~out_valid_reg | out_ready;

    // Memory write on append, probe read on search
    always_ff @(posedge clk)
    begin
        if (ctrl.op == OP_APPEND && !is_full)
            mem[count_reg[IDX_W-1:0]] <= key_reg;
        if (ctrl.op == OP_READ)
        begin
            rd_data_reg <= mem[mid_comb];
            mid_reg     <= mid_comb;
        end
    end

    // Working state updates per operation
    always_comb
    begin
        count_next  = count_reg;
        low_next    = low_reg;
        hi1_next    = hi1_reg;
        wfound_next = wfound_reg;
        wpos_next   = wpos_reg;
        wfull_next  = wfull_reg;
        unique case (ctrl.op)
            OP_CLEAR: begin
                count_next  = '0;
                wfound_next = 1'b0;
                wpos_next   = '0;
                wfull_next  = 1'b0;
            end
            OP_APPEND: begin
                wfound_next = 1'b0;
                wpos_next   = '0;
                wfull_next  = is_full;
                if (!is_full)
                    count_next = count_reg + 1'b1;
            end
            OP_ZERO: begin
                wfound_next = 1'b0;
                wpos_next   = '0;
                wfull_next  = 1'b0;
            end
            OP_SINIT: begin
                low_next    = '0;
                hi1_next    = count_reg;
                wfound_next = 1'b0;
                wpos_next   = '0;
                wfull_next  = 1'b0;
            end
            OP_CMP: begin
                if (key_eq)
                begin
                    wfound_next = 1'b1;
                    wpos_next   = mid_reg;
                end
                else if (key_lt)
                    hi1_next = {1'b0, mid_reg};
                else
                    low_next = {1'b0, mid_reg} + 1'b1;
            end
            default: ;
        endcase
    end

    // Output slot
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.push)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (ctrl.latch)
            key_reg <= value;
        low_reg    <= low_next;
        hi1_reg    <= hi1_next;
        wfound_reg <= wfound_next;
        wpos_reg   <= wpos_next;
        wfull_reg  <= wfull_next;
        if (ctrl.push)
        begin
            found_reg      <= wfound_reg;
            position_reg   <= POS_W'(wpos_reg);
            table_full_reg <= wfull_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign found      = found_reg;
    assign position   = position_reg;
    assign table_full = table_full_reg;

endmodule

FILE: rtl/sorted_table_binary_search_unit.sv
// Top level of the sorted table binary search unit.
//
// Input channel (in_valid/in_ready): one beat carries command and value.
//   command 0 clears the table, 1 appends value at the end, 2 searches for
//   value, 3 is ignored. Appends are expected in ascending order.
// Output channel (out_valid/out_ready): one beat per input beat, carrying
//   found, position and table_full. An append to a full table is dropped
//   and reported with table_full set.
// Steps: clear, append and ignored commands run one operation step, then the
//   result step loads the result register; a search runs an init step, then
//   P probes (each a RAM read step and a compare step) and the result step,
//   plus one read step more on a miss; 1024 entries need up to 11 probes.
// The sequencer works on one item at a time; a new beat is taken in the cycle
//   after the previous result is placed in the output register.
// The output register holds a finished result while the receiver stalls;
//   the next item is accepted and worked on meanwhile, and waits for the
//   output register only at its result step.
// Reset empties the table (the count goes to zero) and drops any result
//   pending; table RAM contents are not cleared.
module sorted_table_binary_search_unit
    import stbs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [CMD_W-1:0]         command,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     found,
    output logic [POS_W-1:0]         position,
    output logic                     table_full
);

    dp_ctrl_t ctrl;
    dp_stat_t stat;

    stbs_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .stat     (stat),
        .in_ready (in_ready),
        .ctrl     (ctrl)
    );

    stbs_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .value      (value),
        .out_ready  (out_ready),
        .stat       (stat),
        .out_valid  (out_valid),
        .found      (found),
        .position   (position),
        .table_full (table_full)
    );

endmodule

FILE: tb/sv/sorted_table_binary_search_unit_tb.sv
// Self-checking testbench of the search unit: queued stimulus, live prediction.
`timescale 1ns / 1ps

module sorted_table_binary_search_unit_tb;
    import stbs_pkg::*;

    localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;
    localparam int TOTAL_ITEMS   = 850;
    localparam int FILL_LEN      = 500;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PRESSURE_AT   = 300;
    localparam int PRESSURE_LEN  = 500;

    typedef struct {
        logic [CMD_W-1:0]         cmd;
        logic signed [DATA_W-1:0] val;
    } beat_t;

    typedef struct {
        logic             found;
        logic [POS_W-1:0] position;
        logic             table_full;
    } answer_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [CMD_W-1:0]         command = CMD_CLEAR;
    logic signed [DATA_W-1:0] value = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic                     found;
    logic [POS_W-1:0]         position;
    logic                     table_full;

    // Stimulus waiting to go out, and answers owed by the block
    beat_t   pending_beats[$];
    answer_t expected_answers[$];

    // Shadow of the table contents as the stimulus generator sees them
    int gen_list[$];

    // Predicted table state
    logic signed [DATA_W-1:0] shadow_table[TABLE_DEPTH];
    logic [CNT_W-1:0]         shadow_count = '0;

    int unsigned tx_wait = 0;
    int unsigned sent_count = 0;
    int unsigned rx_wait = 0;
    int unsigned results_seen = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    int          fault_count = 0;
    int          cycle_count = 0;

    sorted_table_binary_search_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .found      (found),
        .position   (position),
        .table_full (table_full)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Apply one accepted beat to the shadow table and queue its answer
    task automatic table_predict(input logic [CMD_W-1:0] cmd,
                                 input logic signed [DATA_W-1:0] val);
        answer_t ans;
        int      lo;
        int      hi;
        int      mid;
        bit      hit;
        ans.found      = 1'b0;
        ans.position   = '0;
        ans.table_full = 1'b0;
        case (cmd)
            CMD_CLEAR: shadow_count = '0;
            CMD_APPEND:
            begin
                if (shadow_count >= TABLE_DEPTH)
                    ans.table_full = 1'b1;
                else
                begin
                    shadow_table[shadow_count[IDX_W-1:0]] = val;
                    shadow_count = shadow_count + 1'b1;
                end
            end
            CMD_SEARCH:
            begin
                lo  = 0;
                hi  = int'(shadow_count) - 1;
                hit = 1'b0;
                while (!hit && lo <= hi)
                begin
                    mid = (lo + hi) / 2;
                    if (val < shadow_table[mid[IDX_W-1:0]])
                        hi = mid - 1;
                    else if (val > shadow_table[mid[IDX_W-1:0]])
                        lo = mid + 1;
                    else
                    begin
                        hit          = 1'b1;
                        ans.found    = 1'b1;
                        ans.position = mid[POS_W-1:0];
                    end
                end
            end
            default: ;
        endcase
        expected_answers.push_back(ans);
    endtask

    task automatic push_beat(input logic [CMD_W-1:0] cmd, input int val);
        beat_t b;
        b.cmd = cmd;
        b.val = val;
        pending_beats.push_back(b);
    endtask

    // Search key: mostly a stored value, sometimes a near miss, an extreme or a random value
    function automatic int pick_key();
        int r;
        int base;
        r = $urandom_range(0, 9);
        if (gen_list.size() == 0 || r == 9)
            return $urandom;
        base = gen_list[$urandom_range(0, gen_list.size() - 1)];
        if (r < 6)
            return base;
        if (r == 6)
            return base + 1;
        if (r == 7)
            return base - 1;
        return $urandom_range(0, 1) ? int'(32'h7fff_ffff) : int'(32'h8000_0000);
    endfunction

    // Sender gap; every fourth block of 100 beats runs back to back
    function automatic int unsigned draw_tx_gap();
        if ((sent_count / 100) % 4 == 1)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    function automatic int unsigned draw_rx_gap();
        if ((results_seen / 128) % 4 == 2)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    // Input driver
    always @(posedge clk or negedge rst_n)
    begin : driver
        beat_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            command  <= CMD_CLEAR;
            value    <= '0;
            tx_wait  <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                table_predict(command, value);
                sent_count <= sent_count + 1;
            end
            if (in_valid && !in_ready)
            begin
                // hold the beat until taken
            end
            else if (tx_wait != 0)
            begin
                tx_wait  <= tx_wait - 1;
                in_valid <= 1'b0;
            end
            else if (pending_beats.size() != 0)
            begin
                nxt = pending_beats.pop_front();
                command  <= nxt.cmd;
                value    <= nxt.val;
                in_valid <= 1'b1;
                tx_wait  <= draw_tx_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // One long receiver hold-off so the block fills and stalls its input
    always @(posedge clk or negedge rst_n)
    begin : pressure
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && results_seen >= PRESSURE_AT)
        begin
            hold_left <= PRESSURE_LEN;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Result monitor and receiver back-pressure
    always @(posedge clk or negedge rst_n)
    begin : monitor
        answer_t     want;
        int unsigned w;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_wait   <= 0;
        end
        else if (out_valid && out_ready)
        begin
            if (expected_answers.size() == 0)
            begin
                $error("result beat with no outstanding item");
                fault_count++;
            end
            else
            begin
                want = expected_answers.pop_front();
                if (found !== want.found)
                begin
                    $error("found: expected %0d, got %0d", want.found, found);
                    fault_count++;
                end
                if (position !== want.position)
                begin
                    $error("position: expected %0d, got %0d", want.position, position);
                    fault_count++;
                end
                if (table_full !== want.table_full)
                begin
                    $error("table_full: expected %0d, got %0d", want.table_full, table_full);
                    fault_count++;
                end
            end
            w = draw_rx_gap();
            results_seen <= results_seen + 1;
            rx_wait      <= w;
            out_ready    <= (w == 0) && (hold_left == 0);
        end
        else if (rx_wait != 0)
        begin
            rx_wait   <= rx_wait - 1;
            out_ready <= (rx_wait == 1) && (hold_left == 0);
        end
        else
            out_ready <= (hold_left == 0);
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("sorted_table_binary_search_unit: mismatch");
        $finish;
    end

    // Stimulus and end of run
    initial
    begin : stimulus
        int     batch[$];
        int     kind;
        int     n;
        int     i;
        int     v;
        int     c;
        bit     narrow;
        longint acc;

        // Directed: empty table, extremes, misses, ignored command, duplicates, unsorted
        push_beat(CMD_SEARCH, 0);
        push_beat(CMD_CLEAR, 0);
        push_beat(CMD_SEARCH, -1);
        push_beat(CMD_APPEND, int'(32'h8000_0000));
        push_beat(CMD_APPEND, -1);
        push_beat(CMD_APPEND, 0);
        push_beat(CMD_APPEND, 1);
        push_beat(CMD_APPEND, int'(32'h7fff_ffff));
        push_beat(CMD_SEARCH, int'(32'h8000_0000));
        push_beat(CMD_SEARCH, -1);
        push_beat(CMD_SEARCH, 0);
        push_beat(CMD_SEARCH, 1);
        push_beat(CMD_SEARCH, int'(32'h7fff_ffff));
        push_beat(CMD_SEARCH, -2);
        push_beat(CMD_SEARCH, 2);
        push_beat(CMD_SEARCH, int'(32'h7fff_fffe));
        push_beat(CMD_IGNORED, int'(32'hffff_ffff));
        push_beat(CMD_IGNORED, 0);
        push_beat(CMD_APPEND, int'(32'h7fff_ffff));
        push_beat(CMD_SEARCH, int'(32'h7fff_ffff));
        push_beat(CMD_APPEND, -5);
        push_beat(CMD_SEARCH, -5);
        push_beat(CMD_SEARCH, 0);
        push_beat(CMD_CLEAR, 0);
        push_beat(CMD_SEARCH, 0);

        // Long ascending load, then deep searches over it
        push_beat(CMD_CLEAR, 0);
        gen_list.delete();
        acc = -64'sd2147483648 + longint'($urandom_range(0, 1000));
        repeat (FILL_LEN)
        begin
            push_beat(CMD_APPEND, int'(acc));
            gen_list.push_back(int'(acc));
            acc += longint'($urandom_range(1, 8000000));
        end
        push_beat(CMD_SEARCH, gen_list[0]);
        push_beat(CMD_SEARCH, gen_list[FILL_LEN-1]);
        push_beat(CMD_SEARCH, int'(32'h8000_0000));
        push_beat(CMD_SEARCH, int'(32'h7fff_ffff));
        repeat (20) push_beat(CMD_SEARCH, pick_key());
        push_beat(CMD_IGNORED, $urandom);
        push_beat(CMD_CLEAR, 0);
        gen_list.delete();

        // Random: mostly sorted loads followed by searches, some noise
        while (pending_beats.size() < TOTAL_ITEMS)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 6)
            begin
                batch.delete();
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 120)
                                                : $urandom_range(0, 12);
                narrow = ($urandom_range(0, 3) == 0);
                repeat (n)
                begin
                    v = narrow ? int'($urandom_range(0, 30)) - 15 : int'($urandom);
                    i = 0;
                    while (i < batch.size() && batch[i] <= v)
                        i++;
                    batch.insert(i, v);
                end
                // occasionally stack onto the old contents
                if ($urandom_range(0, 6) != 0)
                begin
                    push_beat(CMD_CLEAR, 0);
                    gen_list.delete();
                end
                foreach (batch[j])
                begin
                    push_beat(CMD_APPEND, batch[j]);
                    if (gen_list.size() < TABLE_DEPTH)
                        gen_list.push_back(batch[j]);
                end
                repeat ($urandom_range(1, 12)) push_beat(CMD_SEARCH, pick_key());
            end
            else if (kind == 7)
            begin
                repeat ($urandom_range(1, 6))
                begin
                    c = $urandom_range(0, 3);
                    v = $urandom_range(0, 1) ? pick_key() : int'($urandom);
                    push_beat(c[CMD_W-1:0], v);
                    if (c[CMD_W-1:0] == CMD_CLEAR)
                        gen_list.delete();
                    else if (c[CMD_W-1:0] == CMD_APPEND && gen_list.size() < TABLE_DEPTH)
                        gen_list.push_back(v);
                end
            end
            else if (kind == 8)
                repeat ($urandom_range(1, 3)) push_beat(CMD_IGNORED, $urandom);
            else
                repeat ($urandom_range(1, 8)) push_beat(CMD_SEARCH, pick_key());
        end

        // Reset once
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Drain
        while (pending_beats.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fault_count == 0 && expected_answers.size() == 0)
            $display("sorted_table_binary_search_unit: match");
        else
            $display("sorted_table_binary_search_unit: mismatch");
        $finish;
    end

endmodule
